// File: design/mafs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mafs_pkg - shared types and constants for the MPEG audio frame size block
// Header field codes, bitrate table, constant divisors and their reciprocals,
// and the sideband record that follows each beat down the pipeline.
// ----------------------------------------------------------------------------
package mafs_pkg;

   // Datapath widths
   localparam int DIVIDEND_W  = 20;   // largest dividend is 921600
   localparam int QUOT_W      = 12;   // frame length fits 12 bits
   localparam int DIVISOR_W   = 9;    // largest divisor is 441
   localparam int RECIP_W     = 20;   // largest reciprocal is 2**19
   localparam int RECIP_SHIFT = 24;   // reciprocal scale, above dividend range
   localparam int KBPS_W      = 9;
   localparam int COEF_W      = 13;   // samples/8 scaled by version and rate

   // Version codes (header byte 1, bits 4:3)
   localparam logic [1:0] VER_25   = 2'b00;
   localparam logic [1:0] VER_RSVD = 2'b01;
   localparam logic [1:0] VER_2    = 2'b10;
   localparam logic [1:0] VER_1    = 2'b11;

   // Layer codes (header byte 1, bits 2:1)
   localparam logic [1:0] LYR_RSVD = 2'b00;
   localparam logic [1:0] LYR_3    = 2'b01;
   localparam logic [1:0] LYR_2    = 2'b10;
   localparam logic [1:0] LYR_1    = 2'b11;

   // Sample rate codes (header byte 2, bits 3:2), named by their MPEG-1 rate
   localparam logic [1:0] SR_44K  = 2'b00;
   localparam logic [1:0] SR_48K  = 2'b01;
   localparam logic [1:0] SR_32K  = 2'b10;
   localparam logic [1:0] SR_RSVD = 2'b11;

   localparam logic [7:0] SYNC_BYTE  = 8'hFF;
   localparam logic [2:0] SYNC_BITS  = 3'b111;
   localparam logic [3:0] BRX_BAD    = 4'hF;

   // Base sample rates divided by 1000: 44100 -> 441/10, 48000 -> 48, 32000 -> 32
   localparam int DIV_44K = 441;
   localparam int DIV_48K = 48;
   localparam int DIV_32K = 32;

   localparam logic [RECIP_W-1:0] RECIP_44K = RECIP_W'((2 ** RECIP_SHIFT) / DIV_44K);
   localparam logic [RECIP_W-1:0] RECIP_48K = RECIP_W'((2 ** RECIP_SHIFT) / DIV_48K);
   localparam logic [RECIP_W-1:0] RECIP_32K = RECIP_W'((2 ** RECIP_SHIFT) / DIV_32K);

   // Bitrates in kbit/s by table row and bitrate index (index 15 never read)
   localparam logic [KBPS_W-1:0] KBPS_ROM [0:4][0:15] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   // Sideband carried alongside the arithmetic
   typedef struct packed {
      logic hdr_ok;
      logic pad;
      logic layer_one;
   } side_type;

   function automatic logic [DIVISOR_W-1:0] divisor_of(input logic [1:0] sel);
      logic [DIVISOR_W-1:0] d;
      case (sel)
         SR_44K:  d = DIVISOR_W'(DIV_44K);
         SR_48K:  d = DIVISOR_W'(DIV_48K);
         default: d = DIVISOR_W'(DIV_32K);
      endcase
      return d;
   endfunction

   function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] sel);
      logic [RECIP_W-1:0] m;
      case (sel)
         SR_44K:  m = RECIP_44K;
         SR_48K:  m = RECIP_48K;
         default: m = RECIP_32K;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// File: design/mafs_recip_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mafs_recip_div - two-stage divide by a selected constant
// Stage A multiplies by a scaled reciprocal to get an estimate that is exact
// or one low; stage B forms the remainder and bumps the estimate if needed.
// ----------------------------------------------------------------------------
module mafs_recip_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_stall,
   input  wire logic [mafs_pkg::DIVIDEND_W-1:0]       in_dividend,
   input  wire logic [1:0]                            in_sel,
   input  wire mafs_pkg::side_type                    in_side,
   output logic                                       out_valid,
   input  wire logic                                  out_stall,
   output logic [mafs_pkg::QUOT_W-1:0]                out_quotient,
   output mafs_pkg::side_type                         out_side
);

   localparam int PROD_W = mafs_pkg::DIVIDEND_W + mafs_pkg::RECIP_W;
   localparam int BACK_W = mafs_pkg::DIVIDEND_W + 1;

   // Stage A registers
   logic                              a_valid_ff;
   logic [mafs_pkg::QUOT_W-1:0]       a_est_ff,  a_est_in;
   logic [mafs_pkg::DIVIDEND_W-1:0]   a_x_ff;
   logic [1:0]                        a_sel_ff;
   mafs_pkg::side_type                a_side_ff;

   // Stage B registers
   logic                              b_valid_ff;
   logic [mafs_pkg::QUOT_W-1:0]       b_quot_ff, b_quot_in;
   mafs_pkg::side_type                b_side_ff;

   logic                              a_adv;
   logic                              b_adv;
   logic [PROD_W-1:0]                 est_prod;
   logic [BACK_W-1:0]                 back_prod;
   logic [BACK_W-1:0]                 rem;
   logic [BACK_W-1:0]                 div_ext;

   // Advance a stage when it is empty or its contents move on
   assign b_adv    = !b_valid_ff || !out_stall;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_stall = !a_adv;

   // Estimate: dividend times reciprocal, scaled back down
   always_comb begin
      est_prod = PROD_W'(in_dividend) * PROD_W'(mafs_pkg::recip_of(in_sel));
      a_est_in = est_prod[mafs_pkg::RECIP_SHIFT +: mafs_pkg::QUOT_W];
   end

   // Correct: add one when the remainder reaches the divisor
   always_comb begin
      div_ext   = BACK_W'(mafs_pkg::divisor_of(a_sel_ff));
      back_prod = BACK_W'(a_est_ff) * div_ext;
      rem       = BACK_W'(a_x_ff) - back_prod;
      b_quot_in = a_est_ff + mafs_pkg::QUOT_W'(rem >= div_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) a_valid_ff <= in_valid;
         if (b_adv) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && in_valid) begin
         a_est_ff  <= a_est_in;
         a_x_ff    <= in_dividend;
         a_sel_ff  <= in_sel;
         a_side_ff <= in_side;
      end
      if (b_adv && a_valid_ff) begin
         b_quot_ff <= b_quot_in;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid    = b_valid_ff;
   assign out_quotient = b_quot_ff;
   assign out_side     = b_side_ff;

endmodule
`default_nettype wire

// File: design/mpeg_audio_frame_size.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_frame_size - frame length from an MPEG audio frame header
// Checks the first three header bytes and returns the frame length in bytes
// with a validity flag; invalid headers give length zero.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one header per beat (three bytes); rsp_* returns one beat
//   per header, in order: frame length and a header-valid flag.
//   A beat moves when valid is high and stall is low on that channel.
//   Throughput: one header per cycle while rsp_stall stays low, through a
//   five-stage pipeline (decode and table lookup, coefficient multiply,
//   reciprocal multiply, remainder correction, padding and output register).
//   Reset empties every stage; rsp_valid is low after reset.
//   When the receiver stalls, the output beat holds and the stages behind it
//   keep filling empty slots; req_stall rises only once all stages are full.
//   No configuration and no kept state between headers.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_size (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_header_byte0,
   input  wire logic [7:0]                    req_header_byte1,
   input  wire logic [7:0]                    req_header_byte2,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mafs_pkg::QUOT_W-1:0]        rsp_frame_bytes,
   output logic                               rsp_header_valid
);

   localparam int MUL_W = mafs_pkg::COEF_W + mafs_pkg::KBPS_W;

   // Stage 1: decode
   logic                              s1_valid_ff;
   logic [mafs_pkg::COEF_W-1:0]       s1_coef_ff,  s1_coef_in;
   logic [mafs_pkg::KBPS_W-1:0]       s1_kbps_ff,  s1_kbps_in;
   logic [1:0]                        s1_sel_ff;
   mafs_pkg::side_type                s1_side_ff,  s1_side_in;

   // Stage 2: dividend
   logic                              s2_valid_ff;
   logic [mafs_pkg::DIVIDEND_W-1:0]   s2_x_ff,     s2_x_in;
   logic [1:0]                        s2_sel_ff;
   mafs_pkg::side_type                s2_side_ff;

   // Output stage
   logic                              s5_valid_ff;
   logic [mafs_pkg::QUOT_W-1:0]       s5_len_ff,   s5_len_in;
   logic                              s5_ok_ff;

   logic                              s1_adv, s2_adv, s5_adv;
   logic                              div_in_stall;
   logic                              div_out_valid;
   logic [mafs_pkg::QUOT_W-1:0]       div_quot;
   mafs_pkg::side_type                div_side;

   logic [1:0]                        ver, lyr, srx;
   logic [3:0]                        brx;
   logic                              hdr_ok;
   logic [2:0]                        row;
   logic [7:0]                        spb;
   logic [1:0]                        ver_shift;
   logic [9:0]                        coef_base;
   logic [MUL_W-1:0]                  x_prod;
   logic [mafs_pkg::QUOT_W-1:0]       slots;

   // Back-pressure chain: fill any empty slot
   assign s5_adv    = !s5_valid_ff || !rsp_stall;
   assign s2_adv    = !s2_valid_ff || !div_in_stall;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;

   // Decode header fields and check for sync and reserved codes
   always_comb begin
      ver = req_header_byte1[4:3];
      lyr = req_header_byte1[2:1];
      brx = req_header_byte2[7:4];
      srx = req_header_byte2[3:2];
      hdr_ok = (req_header_byte0 == mafs_pkg::SYNC_BYTE) &&
               (req_header_byte1[7:5] == mafs_pkg::SYNC_BITS) &&
               (ver != mafs_pkg::VER_RSVD) && (lyr != mafs_pkg::LYR_RSVD) &&
               (brx != mafs_pkg::BRX_BAD) && (srx != mafs_pkg::SR_RSVD);

      // Bitrate table row
      if (ver == mafs_pkg::VER_1) begin
         row = 3'd3 - {1'b0, lyr};
      end else if (lyr == mafs_pkg::LYR_1) begin
         row = 3'd3;
      end else begin
         row = 3'd4;
      end

      // Bytes per frame per (bit/s / Hz), before padding (slots for layer I)
      if (lyr == mafs_pkg::LYR_1) begin
         spb = 8'd12;
      end else if (lyr == mafs_pkg::LYR_3 && ver != mafs_pkg::VER_1) begin
         spb = 8'd72;
      end else begin
         spb = 8'd144;
      end

      // Lower versions halve or quarter the sample rate
      case (ver)
         mafs_pkg::VER_1: ver_shift = 2'd0;
         mafs_pkg::VER_2: ver_shift = 2'd1;
         default:         ver_shift = 2'd2;
      endcase
      coef_base = 10'(spb) << ver_shift;

      // The 44.1 kHz family divides by 441 after a factor of ten
      if (!hdr_ok) begin
         s1_coef_in = '0;
      end else if (srx == mafs_pkg::SR_44K) begin
         s1_coef_in = mafs_pkg::COEF_W'(coef_base) * mafs_pkg::COEF_W'(10);
      end else begin
         s1_coef_in = mafs_pkg::COEF_W'(coef_base);
      end

      s1_kbps_in           = hdr_ok ? mafs_pkg::KBPS_ROM[row][brx] : '0;
      s1_side_in.hdr_ok    = hdr_ok;
      s1_side_in.pad       = req_header_byte2[1];
      s1_side_in.layer_one = (lyr == mafs_pkg::LYR_1);
   end

   // Dividend: coefficient times bitrate
   always_comb begin
      x_prod  = MUL_W'(s1_coef_ff) * MUL_W'(s1_kbps_ff);
      s2_x_in = x_prod[mafs_pkg::DIVIDEND_W-1:0];
   end

   // Add padding slot, scale layer I slots to bytes, zero invalid headers
   always_comb begin
      slots = div_quot + mafs_pkg::QUOT_W'(div_side.pad);
      if (!div_side.hdr_ok) begin
         s5_len_in = '0;
      end else if (div_side.layer_one) begin
         s5_len_in = slots << 2;
      end else begin
         s5_len_in = slots;
      end
   end

   mafs_recip_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid_ff),
      .in_stall     (div_in_stall),
      .in_dividend  (s2_x_ff),
      .in_sel       (s2_sel_ff),
      .in_side      (s2_side_ff),
      .out_valid    (div_out_valid),
      .out_stall    (!s5_adv),
      .out_quotient (div_quot),
      .out_side     (div_side)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s5_adv) s5_valid_ff <= div_out_valid;
      end
   end

   // Payload: load only on a moving beat, hold otherwise
   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         s1_coef_ff <= s1_coef_in;
         s1_kbps_ff <= s1_kbps_in;
         s1_sel_ff  <= srx;
         s1_side_ff <= s1_side_in;
      end
      if (s2_adv && s1_valid_ff) begin
         s2_x_ff    <= s2_x_in;
         s2_sel_ff  <= s1_sel_ff;
         s2_side_ff <= s1_side_ff;
      end
      if (s5_adv && div_out_valid) begin
         s5_len_ff <= s5_len_in;
         s5_ok_ff  <= div_side.hdr_ok;
      end
   end

   assign rsp_valid        = s5_valid_ff;
   assign rsp_frame_bytes  = s5_len_ff;
   assign rsp_header_valid = s5_ok_ff;

   // An invalid header always reports length zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_header_valid |-> rsp_frame_bytes == '0)
      else $error("invalid header with non-zero length");

   // An accepted request beat lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted beat lost at decode stage");

   // Input back-pressure only when the decode and dividend stages both hold a beat
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff)
      else $error("stall raised with free pipeline slots");

endmodule
`default_nettype wire

// File: bench/tb_mpeg_audio_frame_size.sv
// ----------------------------------------------------------------------------
// tb_mpeg_audio_frame_size - self-checking bench for the MPEG audio frame size
// Drives three-byte headers through the valid/stall request channel, predicts
// the frame length and validity flag for untyped accepted beats, takes typed
// rows as given, and compares each response beat in order. A directed table
// comes first, then random headers under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_frame_size;

   localparam int RANDOM_PER_PHASE = 250;
   localparam int QUIET_LIMIT      = 5000;
   localparam int TAIL_CYCLES      = 20;

   // Bitrate table rows
   localparam int ROW_V1_L1  = 0;
   localparam int ROW_V1_L2  = 1;
   localparam int ROW_V1_L3  = 2;
   localparam int ROW_V2_L1  = 3;
   localparam int ROW_V2_L23 = 4;

   // Base sample rates for MPEG-1; MPEG-2 halves them, MPEG-2.5 quarters them
   localparam int unsigned HZ_44K = 44100;
   localparam int unsigned HZ_48K = 48000;
   localparam int unsigned HZ_32K = 32000;

   localparam int unsigned BITRATE_KBPS [0:4][0:14] = '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
   };

   typedef struct {
      logic [mafs_pkg::QUOT_W-1:0] frame_bytes;
      logic                        header_valid;
   } frame_len_type;

   // One directed header; typed rows carry their own expected result
   typedef struct packed {
      logic [7:0]                  b0;
      logic [7:0]                  b1;
      logic [7:0]                  b2;
      logic                        typed;
      logic [mafs_pkg::QUOT_W-1:0] fixed_bytes;
      logic                        fixed_valid;
   } header_case_type;

   localparam int DIRECTED_N = 22;
   localparam header_case_type DIRECTED [0:DIRECTED_N-1] = '{
      '{8'h00, 8'h00, 8'h00, 1'b1, 12'd0,    1'b0},  // all zero
      '{8'hFF, 8'hFF, 8'hFF, 1'b1, 12'd0,    1'b0},  // all ones: bad bitrate
      '{8'hFE, 8'hFB, 8'h90, 1'b1, 12'd0,    1'b0},  // first sync byte wrong
      '{8'hFF, 8'hDB, 8'h90, 1'b1, 12'd0,    1'b0},  // low sync bit of byte 1
      '{8'hFF, 8'h7B, 8'h90, 1'b1, 12'd0,    1'b0},  // high sync bit of byte 1
      '{8'hFF, 8'hEB, 8'h90, 1'b1, 12'd0,    1'b0},  // reserved version
      '{8'hFF, 8'hF9, 8'h90, 1'b1, 12'd0,    1'b0},  // reserved layer
      '{8'hFF, 8'hFB, 8'hF0, 1'b1, 12'd0,    1'b0},  // bitrate index 15
      '{8'hFF, 8'hFB, 8'h9C, 1'b1, 12'd0,    1'b0},  // reserved sample rate
      '{8'hFF, 8'hFB, 8'h00, 1'b1, 12'd0,    1'b1},  // free format, no padding
      '{8'hFF, 8'hFB, 8'h02, 1'b1, 12'd1,    1'b1},  // free format, padded L-III
      '{8'hFF, 8'hFF, 8'h02, 1'b1, 12'd4,    1'b1},  // free format, padded L-I
      '{8'hFF, 8'hE4, 8'hEA, 1'b1, 12'd2881, 1'b1},  // longest frame
      '{8'hFF, 8'hFB, 8'h90, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hFD, 8'hE4, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hFF, 8'hE6, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hF3, 8'h18, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hF7, 8'hEB, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hE2, 8'hA1, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hE7, 8'h12, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hF5, 8'h54, 1'b0, 12'd0,    1'b0},
      '{8'hFF, 8'hFE, 8'hE8, 1'b0, 12'd0,    1'b0}
   };

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [7:0]                  req_header_byte0;
   logic [7:0]                  req_header_byte1;
   logic [7:0]                  req_header_byte2;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [mafs_pkg::QUOT_W-1:0] rsp_frame_bytes;
   logic                        rsp_header_valid;

   // Bench-side companions of the request beat
   logic                        req_typed;
   logic [mafs_pkg::QUOT_W-1:0] req_fixed_bytes;
   logic                        req_fixed_valid;

   frame_len_type pending_lengths [$];
   int            send_idle_pct;
   int            rsp_stall_pct;
   int            quiet_cycles;
   int            mismatches;
   int            valid_seen;
   int            rejected_seen;

   mpeg_audio_frame_size i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_header_byte0 (req_header_byte0),
      .req_header_byte1 (req_header_byte1),
      .req_header_byte2 (req_header_byte2),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_bytes  (rsp_frame_bytes),
      .rsp_header_valid (rsp_header_valid)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Frame length in bytes for one header, zero with the flag low if rejected
   function automatic frame_len_type predict_frame_len(input logic [7:0] b0, b1, b2);
      frame_len_type r;
      logic [1:0]    ver;
      logic [1:0]    lyr;
      logic [1:0]    srx;
      logic [3:0]    brx;
      logic          pad;
      int            row;
      int unsigned   kbps;
      int unsigned   hz;
      int unsigned   per_frame;
      int unsigned   len;
      ver = b1[4:3];
      lyr = b1[2:1];
      brx = b2[7:4];
      srx = b2[3:2];
      pad = b2[1];
      r.frame_bytes  = '0;
      r.header_valid = 1'b0;
      if (b0 != mafs_pkg::SYNC_BYTE || b1[7:5] != mafs_pkg::SYNC_BITS ||
          ver == mafs_pkg::VER_RSVD || lyr == mafs_pkg::LYR_RSVD ||
          brx == mafs_pkg::BRX_BAD || srx == mafs_pkg::SR_RSVD)
         return r;
      if (ver == mafs_pkg::VER_1) begin
         case (lyr)
            mafs_pkg::LYR_1: row = ROW_V1_L1;
            mafs_pkg::LYR_2: row = ROW_V1_L2;
            default:         row = ROW_V1_L3;
         endcase
      end else begin
         row = (lyr == mafs_pkg::LYR_1) ? ROW_V2_L1 : ROW_V2_L23;
      end
      kbps = BITRATE_KBPS[row][brx];
      case (srx)
         mafs_pkg::SR_44K: hz = HZ_44K;
         mafs_pkg::SR_48K: hz = HZ_48K;
         default:          hz = HZ_32K;
      endcase
      if (ver == mafs_pkg::VER_2)
         hz = hz / 2;
      else if (ver == mafs_pkg::VER_25)
         hz = hz / 4;
      // Layer I counts in four-byte slots, padding included
      if (lyr == mafs_pkg::LYR_1) begin
         len = 4 * ((12 * kbps * 1000) / hz + pad);
      end else begin
         per_frame = (lyr == mafs_pkg::LYR_3 && ver != mafs_pkg::VER_1) ? 72 : 144;
         len = (per_frame * kbps * 1000) / hz + pad;
      end
      r.frame_bytes  = len[mafs_pkg::QUOT_W-1:0];
      r.header_valid = 1'b1;
      return r;
   endfunction

   // Mostly well-formed headers with random content, some broken, some noise
   task automatic make_header(output logic [7:0] b0, b1, b2);
      logic [1:0] ver;
      logic [1:0] lyr;
      logic [1:0] srx;
      logic [3:0] brx;
      int         kind;
      kind = $urandom_range(99);
      case ($urandom_range(2))
         0:       ver = mafs_pkg::VER_1;
         1:       ver = mafs_pkg::VER_2;
         default: ver = mafs_pkg::VER_25;
      endcase
      case ($urandom_range(2))
         0:       lyr = mafs_pkg::LYR_1;
         1:       lyr = mafs_pkg::LYR_2;
         default: lyr = mafs_pkg::LYR_3;
      endcase
      brx = 4'($urandom_range(14));
      srx = 2'($urandom_range(2));
      b0 = mafs_pkg::SYNC_BYTE;
      b1 = {mafs_pkg::SYNC_BITS, ver, lyr, 1'($urandom_range(1))};
      b2 = {brx, srx, 1'($urandom_range(1)), 1'($urandom_range(1))};
      if (kind >= 70 && kind < 85) begin
         // break exactly one field
         case ($urandom_range(5))
            0: b0 = 8'($urandom_range(254));
            1: b1[7:5] = 3'($urandom_range(6));
            2: b1[4:3] = mafs_pkg::VER_RSVD;
            3: b1[2:1] = mafs_pkg::LYR_RSVD;
            4: b2[7:4] = mafs_pkg::BRX_BAD;
            default: b2[3:2] = mafs_pkg::SR_RSVD;
         endcase
      end else if (kind >= 85) begin
         b0 = 8'($urandom);
         b1 = 8'($urandom);
         b2 = 8'($urandom);
      end
   endtask

   // Present one beat after a random gap and hold it until accepted
   task automatic send_header(input logic [7:0] b0, b1, b2, input logic typed,
                              input logic [mafs_pkg::QUOT_W-1:0] fixed_bytes,
                              input logic fixed_valid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_header_byte0 <= b0;
      req_header_byte1 <= b1;
      req_header_byte2 <= b2;
      req_typed        <= typed;
      req_fixed_bytes  <= fixed_bytes;
      req_fixed_valid  <= fixed_valid;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      for (int n = 0; n < count; n++) begin
         make_header(b0, b1, b2);
         send_header(b0, b1, b2, 1'b0, '0, 1'b0);
      end
   endtask

   // Receiver back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   // Queue the expected length per request beat, check each response beat
   always @(posedge clock) begin : length_check
      frame_len_type want;
      logic          moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         moved = 1'b1;
         if (req_typed) begin
            want.frame_bytes  = req_fixed_bytes;
            want.header_valid = req_fixed_valid;
         end else begin
            want = predict_frame_len(req_header_byte0, req_header_byte1,
                                     req_header_byte2);
         end
         pending_lengths.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (pending_lengths.size() == 0) begin
            $display("%0t: response beat with nothing expected (bytes %0d valid %0b)",
                     $time, rsp_frame_bytes, rsp_header_valid);
            mismatches++;
         end else begin
            want = pending_lengths.pop_front();
            if (rsp_frame_bytes !== want.frame_bytes) begin
               $display("%0t: frame_bytes expected %0d got %0d",
                        $time, want.frame_bytes, rsp_frame_bytes);
               mismatches++;
            end
            if (rsp_header_valid !== want.header_valid) begin
               $display("%0t: header_valid expected %0b got %0b",
                        $time, want.header_valid, rsp_header_valid);
               mismatches++;
            end
            if (rsp_header_valid === 1'b1)
               valid_seen++;
            else
               rejected_seen++;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // Abort if nothing moves for too long
   initial begin : watchdog
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL mpeg_audio_frame_size");
      $finish;
   end

   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_header_byte0 = '0;
      req_header_byte1 = '0;
      req_header_byte2 = '0;
      req_typed        = 1'b0;
      req_fixed_bytes  = '0;
      req_fixed_valid  = 1'b0;
      send_idle_pct    = 8;
      rsp_stall_pct    = 56;
      quiet_cycles     = 0;
      mismatches       = 0;
      valid_seen       = 0;
      rejected_seen    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, then random headers under the first idle mix
      for (int k = 0; k < DIRECTED_N; k++)
         send_header(DIRECTED[k].b0, DIRECTED[k].b1, DIRECTED[k].b2,
                     DIRECTED[k].typed, DIRECTED[k].fixed_bytes,
                     DIRECTED[k].fixed_valid);
      send_random(RANDOM_PER_PHASE);

      // Swap the idle mix round, then run flat out
      send_idle_pct = 56;
      rsp_stall_pct = 8;
      send_random(RANDOM_PER_PHASE);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      // Drain, then watch for stray beats
      while (pending_lengths.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d headers: %0d valid frame lengths, %0d rejected headers.",
               valid_seen + rejected_seen, valid_seen, rejected_seen);
      $display("Idle mixes: light sender/heavy receiver, heavy sender/light receiver, none; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && pending_lengths.size() == 0)
         $display("PASS mpeg_audio_frame_size");
      else
         $display("FAIL mpeg_audio_frame_size");
      $finish;
   end

endmodule
